// File: src/mbe_pkg.sv
// Shared types and constants for the escape-time pixel engine.
// Holds the configuration layout, the mapped point type and the state encodings.
// No dependencies.
`default_nettype none

package mbe_pkg;

  // Word widths of the fixed-point values, register indexes, image sizes and limits.
  localparam int FIX_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 13;
  localparam int LIMIT_W   = 16;

  typedef logic signed [FIX_W-1:0] fix_t;
  typedef logic        [FIX_W-1:0] ufix_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RE_MIN       = 3'd0,
    REG_RE_MAX       = 3'd1,
    REG_IM_MIN       = 3'd2,
    REG_IM_MAX       = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_ESCAPE_LIMIT = 3'd6,
    REG_ITER_LIMIT   = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam fix_t             RST_RE_MIN       = -32'sd671088640;
  localparam fix_t             RST_RE_MAX       = 32'sd268435456;
  localparam fix_t             RST_IM_MIN       = -32'sd268435456;
  localparam fix_t             RST_IM_MAX       = 32'sd268435456;
  localparam logic [SIZE_W-1:0]  RST_WIDTH      = 13'd1280;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 13'd1024;
  localparam ufix_t            RST_ESCAPE       = 32'd1073741824;
  localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd1000;

  // Configuration as seen by the front and back halves.
  typedef struct packed {
    fix_t               re_min;
    fix_t               re_max;
    fix_t               im_min;
    fix_t               im_max;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    ufix_t              escape_limit;
    logic [LIMIT_W-1:0] iteration_limit;
  } cfg_t;

  // Point c = p + i*q handed from the mapper to the iteration engine.
  typedef struct packed {
    fix_t p;
    fix_t q;
  } point_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_MUL,
    B_SQ,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// File: src/mbe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the coordinate mapper; no package dependencies.
`default_nettype none

module mbe_div #(
  parameter int DW = 44,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          fits;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem, quotient[DW-1]};
    diff   = rem_sh - {1'b0, dvs};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  // Control: count down the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  // Datapath: the quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: src/mbe_fifo.sv
// Small register queue that decouples the mapper from the iteration engine.
// No package dependencies; depth must be a power of two.
`default_nettype none

module mbe_fifo #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == (AW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

endmodule

`default_nettype wire

// File: src/mbe_front.sv
// Coordinate mapper: turns a pixel index into a point of the complex plane.
// Uses mbe_pkg and two mbe_div instances for the column and row scaling.
`default_nettype none

module mbe_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic                  push,
  output logic                  full,
  input  mbe_pkg::cfg_t         cfg,
  output mbe_pkg::point_t       pt,
  output logic                  pt_push,
  input  logic                  pt_full
);

  import mbe_pkg::*;

  localparam int PW = COORD_BITS + FIX_W;
  localparam int SW = PW + 2;

  front_state_t state, state_next;

  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic                  neg_re;
  logic                  neg_im;
  logic [PW-1:0]         prod_re;
  logic [PW-1:0]         prod_im;

  logic                  take;
  logic                  div_start;
  logic                  busy_re;
  logic                  busy_im;
  logic [PW-1:0]         quo_re;
  logic [PW-1:0]         quo_im;
  logic signed [FIX_W:0] span_re;
  logic signed [FIX_W:0] span_im;
  logic [FIX_W-1:0]      mag_re;
  logic [FIX_W-1:0]      mag_im;
  logic [SIZE_W-1:0]     dvs_re;
  logic [SIZE_W-1:0]     dvs_im;
  logic signed [SW-1:0]  off_re;
  logic signed [SW-1:0]  off_im;
  logic signed [SW-1:0]  sum_re;
  logic signed [SW-1:0]  sum_im;

  // Window spans in sign-magnitude form; a zero image size counts as one.
  always_comb begin
    span_re = {cfg.re_max[FIX_W-1], cfg.re_max} - {cfg.re_min[FIX_W-1], cfg.re_min};
    span_im = {cfg.im_max[FIX_W-1], cfg.im_max} - {cfg.im_min[FIX_W-1], cfg.im_min};
    mag_re  = span_re[FIX_W] ? FIX_W'(-span_re) : span_re[FIX_W-1:0];
    mag_im  = span_im[FIX_W] ? FIX_W'(-span_im) : span_im[FIX_W-1:0];
    dvs_re  = (cfg.image_width == '0) ? SIZE_W'(1) : cfg.image_width;
    dvs_im  = (cfg.image_height == '0) ? SIZE_W'(1) : cfg.image_height;
  end

  mbe_div #(.DW(PW), .VW(SIZE_W)) u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_re),
    .divisor  (dvs_re),
    .busy     (busy_re),
    .quotient (quo_re)
  );

  mbe_div #(.DW(PW), .VW(SIZE_W)) u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_im),
    .divisor  (dvs_im),
    .busy     (busy_im),
    .quotient (quo_im)
  );

  // Restore the sign, add the window origin and saturate to the point width.
  always_comb begin
    off_re = neg_re ? -SW'(quo_re) : SW'(quo_re);
    off_im = neg_im ? -SW'(quo_im) : SW'(quo_im);
    sum_re = SW'(cfg.re_min) + off_re;
    sum_im = SW'(cfg.im_min) + off_im;
    if (sum_re[SW-1:FIX_W-1] == '0 || sum_re[SW-1:FIX_W-1] == '1) begin
      pt.p = sum_re[FIX_W-1:0];
    end else begin
      pt.p = sum_re[SW-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end
    if (sum_im[SW-1:FIX_W-1] == '0 || sum_im[SW-1:FIX_W-1] == '1) begin
      pt.q = sum_im[FIX_W-1:0];
    end else begin
      pt.q = sum_im[SW-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (take) state_next = F_MUL;
      F_MUL:   state_next = F_START;
      F_START: state_next = F_DIV;
      F_DIV:   if (!busy_re && !busy_im) state_next = F_PUSH;
      F_PUSH:  if (!pt_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    full      = (state != F_IDLE);
    take      = push && (state == F_IDLE);
    div_start = (state == F_START);
    pt_push   = (state == F_PUSH) && !pt_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pixel capture and the scaling products.
  always_ff @(posedge clk) begin
    if (take) begin
      col <= pixel_col;
      row <= pixel_row;
    end
    if (state == F_MUL) begin
      prod_re <= PW'(col) * PW'(mag_re);
      prod_im <= PW'(row) * PW'(mag_im);
      neg_re  <= span_re[FIX_W];
      neg_im  <= span_im[FIX_W];
    end
  end

endmodule

`default_nettype wire

// File: src/mbe_back.sv
// Iteration engine: runs z = z^2 + c in three-square form and holds the result word.
// Uses mbe_pkg; fed from the point queue.
`default_nettype none

module mbe_back #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mbe_pkg::cfg_t         cfg,
  input  mbe_pkg::point_t       pt,
  input  logic                  pt_empty,
  output logic                  pt_pop,
  output logic [COUNT_BITS-1:0] iter_count,
  output logic                  escaped,
  output logic                  empty,
  input  logic                  pop
);

  import mbe_pkg::*;

  localparam int LIM_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int EW    = FIX_W + 3;
  localparam int PRW   = 2 * FIX_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  back_state_t state, state_next;

  fix_t                  p;
  fix_t                  q;
  ufix_t                 x2;
  ufix_t                 y2;
  ufix_t                 w;
  logic [COUNT_BITS-1:0] it;
  ufix_t                 mx;
  ufix_t                 my;
  ufix_t                 mw;
  logic [PRW-1:0]        px;
  logic [PRW-1:0]        py;
  logic [PRW-1:0]        pw;
  logic                  out_valid;

  logic [LIM_W-1:0]      limit_ext;
  logic [COUNT_BITS-1:0] limit;
  logic                  go;
  logic                  load;
  logic                  out_load;
  logic signed [EW-1:0]  ex2;
  logic signed [EW-1:0]  ey2;
  logic signed [EW-1:0]  ew;
  logic signed [EW-1:0]  x1w;
  logic signed [EW-1:0]  y1w;
  fix_t                  x1;
  fix_t                  y1;
  logic signed [FIX_W:0] s;
  logic [FIX_W:0]        s_mag;

  // Saturate a wide signed sum to the point width.
  function automatic fix_t sat_fix(input logic signed [EW-1:0] v);
    fix_t r;
    if (v[EW-1:FIX_W-1] == '0 || v[EW-1:FIX_W-1] == '1) begin
      r = v[FIX_W-1:0];
    end else begin
      r = v[EW-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Drop the fraction bits of a square and saturate to the unsigned word.
  function automatic ufix_t sq_sat(input logic [PRW-1:0] prod);
    logic [PRW-1:0] sh;
    sh = prod >> FRAC_BITS;
    return (|sh[PRW-1:FIX_W]) ? {FIX_W{1'b1}} : sh[FIX_W-1:0];
  endfunction

  // Effective iteration limit, clamped to what the counter can hold.
  always_comb begin
    limit_ext = LIM_W'(cfg.iteration_limit);
    limit     = (limit_ext > LIM_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(limit_ext);
  end

  // Loop test, then the next x1, y1 and the magnitudes to be squared.
  always_comb begin
    go    = (({1'b0, x2} + {1'b0, y2}) <= {1'b0, cfg.escape_limit}) && (it < limit);
    ex2   = EW'(x2);
    ey2   = EW'(y2);
    ew    = EW'(w);
    x1w   = ex2 - ey2 + EW'(p);
    y1w   = ew - ex2 - ey2 + EW'(q);
    x1    = sat_fix(x1w);
    y1    = sat_fix(y1w);
    s     = (FIX_W + 1)'(x1) + (FIX_W + 1)'(y1);
    s_mag = s[FIX_W] ? -s : s;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!pt_empty) state_next = B_CHECK;
      B_CHECK: state_next = go ? B_MUL : B_DONE;
      B_MUL:   state_next = B_SQ;
      B_SQ:    state_next = B_CHECK;
      B_DONE:  if (!out_valid || pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load     = (state == B_IDLE) && !pt_empty;
    pt_pop   = load;
    out_load = (state == B_DONE) && (!out_valid || pop);
    empty    = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Iteration datapath: check, square, fold back.
  always_ff @(posedge clk) begin
    if (load) begin
      p  <= pt.p;
      q  <= pt.q;
      x2 <= '0;
      y2 <= '0;
      w  <= '0;
      it <= '0;
    end
    if (state == B_CHECK) begin
      mx <= x1[FIX_W-1] ? -x1 : x1;
      my <= y1[FIX_W-1] ? -y1 : y1;
      mw <= s_mag[FIX_W] ? {FIX_W{1'b1}} : s_mag[FIX_W-1:0];
    end
    if (state == B_MUL) begin
      px <= PRW'(mx) * PRW'(mx);
      py <= PRW'(my) * PRW'(my);
      pw <= PRW'(mw) * PRW'(mw);
    end
    if (state == B_SQ) begin
      x2 <= sq_sat(px);
      y2 <= sq_sat(py);
      w  <= sq_sat(pw);
      it <= it + 1'b1;
    end
    if (out_load) begin
      iter_count <= it;
      escaped    <= (it < limit);
    end
  end

endmodule

`default_nettype wire

// File: src/mandelbrot_escape_time.sv
// Escape-time pixel engine. The mapper scales each pixel through serial dividers and the engine
// runs each iteration through its check, multiply and square states. The mapper takes a new
// pixel only once it has pushed the last point, and the engine takes a new point only once its
// result word is loaded; a two-word queue between the two halves lets them overlap.
// Reset is synchronous: it empties both sides and restores the window,
// image size and limits to their defaults. There is no clearing pass.
`default_nettype none

module mandelbrot_escape_time #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [COORD_BITS-1:0]          pixel_col,
  input  logic [COORD_BITS-1:0]          pixel_row,
  output logic                           empty,
  input  logic                           pop,
  output logic [COUNT_BITS-1:0]          iter_count,
  output logic                           escaped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::FIX_W-1:0]      cfg_data
);

  import mbe_pkg::*;

  cfg_t   cfg;
  point_t front_pt;
  point_t back_pt;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.re_min          <= RST_RE_MIN;
      cfg.re_max          <= RST_RE_MAX;
      cfg.im_min          <= RST_IM_MIN;
      cfg.im_max          <= RST_IM_MAX;
      cfg.image_width     <= RST_WIDTH;
      cfg.image_height    <= RST_HEIGHT;
      cfg.escape_limit    <= RST_ESCAPE;
      cfg.iteration_limit <= RST_ITER_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RE_MIN:       cfg.re_min          <= cfg_data;
        REG_RE_MAX:       cfg.re_max          <= cfg_data;
        REG_IM_MIN:       cfg.im_min          <= cfg_data;
        REG_IM_MAX:       cfg.im_max          <= cfg_data;
        REG_IMAGE_WIDTH:  cfg.image_width     <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height    <= cfg_data[SIZE_W-1:0];
        REG_ESCAPE_LIMIT: cfg.escape_limit    <= cfg_data;
        REG_ITER_LIMIT:   cfg.iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Mapper.
  mbe_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .push      (push),
    .full      (full),
    .cfg       (cfg),
    .pt        (front_pt),
    .pt_push   (q_push),
    .pt_full   (q_full)
  );

  // Point queue between the two halves.
  mbe_fifo #(.W($bits(point_t)), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (front_pt),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (back_pt),
    .empty (q_empty)
  );

  // Iteration engine with the result word register.
  mbe_back #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pt         (back_pt),
    .pt_empty   (q_empty),
    .pt_pop     (q_pop),
    .iter_count (iter_count),
    .escaped    (escaped),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

// File: src/mbe_checker.sv
// Port-level checks for the escape-time engine, bound to its top level.
// Depends only on the top-level port list.
`default_nettype none

module mbe_checker #(
  parameter int COUNT_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [COUNT_BITS-1:0] iter_count,
  input logic                  escaped
);

  // Reset leaves no result word behind.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  // Reset frees the input side.
  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // A waiting result word holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(iter_count) && $stable(escaped)))
    else $error("waiting result word changed");

  // An escaped point always ran at least one iteration.
  a_escape_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && escaped) |-> (iter_count != '0))
    else $error("escaped point with zero iterations");

endmodule

bind mandelbrot_escape_time mbe_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (.*);

`default_nettype wire
